// ----- rtl/core/bpa_pkg.sv -----
// Shared types and constants for the buddy page allocator.
// Depends on nothing; the interfaces and the allocator refer to it by scoped names, the testbench imports it.
package bpa_pkg;

  // Pool geometry
  localparam int unsigned NUM_PAGES  = 1024;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);
  localparam int unsigned LINK_W     = PAGE_W + 1;
  localparam int unsigned POOL_ORDER = $clog2(NUM_PAGES + 1) - 1;
  localparam int unsigned NUM_ORDERS = POOL_ORDER + 1;
  localparam int unsigned ORDER_W    = $clog2(NUM_ORDERS + 1);
  localparam int unsigned PAGES_W    = 33 - PAGE_SHIFT;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_PAGES);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOBLOCK = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Page frame kinds
  typedef enum logic [1:0] {
    KIND_INNER = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USED  = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SIZE,
    S_A_SRCH,
    S_A_SPLIT,
    S_RM_RD,
    S_RM_W1,
    S_RM_W2,
    S_PUSH1,
    S_PUSH2,
    S_F_CHK,
    S_F_TEST,
    S_MG_TOP,
    S_MG_TEST,
    S_MG_RMLO,
    S_MG_FIX,
    S_FIN
  } state_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ----- rtl/core/bpa_req_if.sv -----
// Request channel of the buddy page allocator: valid, ready and one request.
// Depends on bpa_pkg.
interface bpa_req_if;
  logic          valid;
  logic          ready;
  bpa_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/bpa_rsp_if.sv -----
// Result channel of the buddy page allocator: valid, ready and one result.
// Depends on bpa_pkg.
interface bpa_rsp_if;
  logic          valid;
  logic          ready;
  bpa_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/buddy_page_allocator.sv -----
// Buddy page allocator: sequencer, per-page frame memories and free-list registers.
// Depends on bpa_pkg, bpa_req_if and bpa_rsp_if.
//
//   channel   direction  contents
//   req_i     in         operation, request_size, free_address
//   rsp_o     out        block_address, status
//   cfg       in         cfg_we_i / cfg_wdata_i write region_base
//
// One transaction at a time through a small sequencer that walks the lists step by step.
// Allocate: round the size up to an order, search up the orders for a non-empty list,
// unlink its head, split off one upper half per order above the one wanted, then hand over.
// Free: check the address, test the page kind, then merge with free buddies one order at a time.
// After reset the frame memories are cleared, one page a cycle, with req_i not ready.
// A finished result waits in the output register while the next request is taken;
// the sequencer holds in its last state while that register is still full.
module buddy_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bpa_req_if.sink     req_i,
  bpa_rsp_if.source   rsp_o
);

  localparam int unsigned PW = bpa_pkg::PAGE_W;
  localparam int unsigned LW = bpa_pkg::LINK_W;
  localparam int unsigned OW = bpa_pkg::ORDER_W;

  // Frame memories
  bpa_pkg::kind_e kind_mem  [bpa_pkg::NUM_PAGES];
  logic [OW-1:0]  order_mem [bpa_pkg::NUM_PAGES];
  logic [LW-1:0]  next_mem  [bpa_pkg::NUM_PAGES];
  logic [LW-1:0]  prev_mem  [bpa_pkg::NUM_PAGES];

  bpa_pkg::kind_e kind_rd;
  logic [OW-1:0]  order_rd;
  logic [LW-1:0]  next_rd, prev_rd;
  logic [PW-1:0]  rd_addr;

  logic           kind_we, order_we, next_we, prev_we;
  logic [PW-1:0]  kind_wa, order_wa, next_wa, prev_wa;
  bpa_pkg::kind_e kind_wd;
  logic [OW-1:0]  order_wd;
  logic [LW-1:0]  next_wd, prev_wd;

  // Free-list ends
  logic [LW-1:0] head_q [bpa_pkg::NUM_ORDERS];
  logic [LW-1:0] tail_q [bpa_pkg::NUM_ORDERS];
  logic          head_we, tail_we;
  logic [LW-1:0] head_wd, tail_wd;

  // Sequencer registers
  bpa_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [PW-1:0]   clr_q, clr_d;
  logic [31:0]     addr_q, addr_d;
  logic [bpa_pkg::PAGES_W-1:0] pages_q, pages_d;
  logic [OW-1:0]   want_q, want_d, ord_q, ord_d, lst_q, lst_d;
  logic [PW-1:0]   v_q, v_d, b_q, b_d, x_q, x_d;
  logic [LW-1:0]   t_q, t_d;
  logic [31:0]     res_addr_q, res_addr_d;
  bpa_pkg::status_e res_stat_q, res_stat_d;
  logic [31:0]     base_q;
  logic            out_vld_q, out_vld_d;
  bpa_pkg::rsp_t   out_q, out_d;

  // Shared conditions
  logic          acc, load_out;
  logic          size_big, size_fits, srch_fail;
  logic [LW-1:0] head_sel, tail_sel;
  logic [31:0]   off;
  logic          free_ok;
  logic [PW-1:0] buddy, split_buddy;
  logic          merge_ok;
  logic [32:0]   size_sum;

  assign acc       = req_i.valid && req_i.ready;
  assign load_out  = (state_q == bpa_pkg::S_FIN) && (!out_vld_q || rsp_o.ready);
  assign size_sum  = {1'b0, req_i.data.request_size} + 33'(bpa_pkg::PAGE_BYTES - 1);
  assign size_big  = want_q > OW'(bpa_pkg::POOL_ORDER);
  assign size_fits = !((bpa_pkg::PAGES_W'(1) << want_q) < pages_q);
  assign srch_fail = ord_q > OW'(bpa_pkg::POOL_ORDER);
  assign head_sel  = srch_fail ? bpa_pkg::LINK_NULL : head_q[ord_q];
  assign tail_sel  = tail_q[lst_q];
  assign off       = addr_q - base_q;
  assign free_ok   = (addr_q != 32'd0) && (addr_q >= base_q)
                     && (off[bpa_pkg::PAGE_SHIFT-1:0] == '0)
                     && (off[31:bpa_pkg::PAGE_SHIFT+PW] == '0);
  assign buddy       = v_q ^ (PW'(1) << ord_q);
  assign split_buddy = v_q ^ (PW'(1) << (ord_q - OW'(1)));
  assign merge_ok    = (kind_rd == bpa_pkg::KIND_FREE) && (order_rd == ord_q);

  assign req_i.ready = (state_q == bpa_pkg::S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        if (clr_q == PW'(bpa_pkg::NUM_PAGES - 1)) state_d = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (acc) begin
          state_d = (req_i.data.operation == bpa_pkg::OP_FREE) ? bpa_pkg::S_F_CHK
                                                               : bpa_pkg::S_A_SIZE;
        end
      end
      bpa_pkg::S_A_SIZE: begin
        if (size_big) state_d = bpa_pkg::S_FIN;
        else if (size_fits) state_d = bpa_pkg::S_A_SRCH;
      end
      bpa_pkg::S_A_SRCH: begin
        if (srch_fail) state_d = bpa_pkg::S_FIN;
        else if (head_sel != bpa_pkg::LINK_NULL) state_d = bpa_pkg::S_RM_RD;
      end
      bpa_pkg::S_A_SPLIT: begin
        state_d = (ord_q > want_q) ? bpa_pkg::S_PUSH1 : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_RM_RD:   state_d = bpa_pkg::S_RM_W1;
      bpa_pkg::S_RM_W1:   state_d = bpa_pkg::S_RM_W2;
      bpa_pkg::S_RM_W2:   state_d = ret_q;
      bpa_pkg::S_PUSH1: begin
        state_d = (tail_sel == bpa_pkg::LINK_NULL) ? ret_q : bpa_pkg::S_PUSH2;
      end
      bpa_pkg::S_PUSH2:   state_d = ret_q;
      bpa_pkg::S_F_CHK: begin
        state_d = free_ok ? bpa_pkg::S_F_TEST : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_F_TEST: begin
        state_d = (kind_rd == bpa_pkg::KIND_USED) ? bpa_pkg::S_PUSH1 : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_MG_TOP: begin
        state_d = (ord_q >= OW'(bpa_pkg::POOL_ORDER)) ? bpa_pkg::S_FIN : bpa_pkg::S_MG_TEST;
      end
      bpa_pkg::S_MG_TEST: begin
        state_d = merge_ok ? bpa_pkg::S_RM_RD : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_MG_RMLO: state_d = bpa_pkg::S_RM_RD;
      bpa_pkg::S_MG_FIX:  state_d = bpa_pkg::S_PUSH1;
      bpa_pkg::S_FIN: begin
        if (load_out) state_d = bpa_pkg::S_IDLE;
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory writes and list updates
  always_comb begin
    ret_d      = ret_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    pages_d    = pages_q;
    want_d     = want_q;
    ord_d      = ord_q;
    lst_d      = lst_q;
    v_d        = v_q;
    b_d        = b_q;
    x_d        = x_q;
    t_d        = t_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    rd_addr    = x_q;
    kind_we    = 1'b0;
    kind_wa    = x_q;
    kind_wd    = bpa_pkg::KIND_FREE;
    order_we   = 1'b0;
    order_wa   = x_q;
    order_wd   = lst_q;
    next_we    = 1'b0;
    next_wa    = x_q;
    next_wd    = bpa_pkg::LINK_NULL;
    prev_we    = 1'b0;
    prev_wa    = x_q;
    prev_wd    = bpa_pkg::LINK_NULL;
    head_we    = 1'b0;
    head_wd    = bpa_pkg::LINK_NULL;
    tail_we    = 1'b0;
    tail_wd    = bpa_pkg::LINK_NULL;

    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        // Wipe one page a cycle; page 0 becomes the single maximal free block
        kind_we  = 1'b1;
        kind_wa  = clr_q;
        kind_wd  = (clr_q == '0) ? bpa_pkg::KIND_FREE : bpa_pkg::KIND_INNER;
        order_we = 1'b1;
        order_wa = clr_q;
        order_wd = (clr_q == '0) ? OW'(bpa_pkg::POOL_ORDER) : '0;
        next_we  = 1'b1;
        next_wa  = clr_q;
        prev_we  = 1'b1;
        prev_wa  = clr_q;
        clr_d    = clr_q + PW'(1);
      end
      bpa_pkg::S_IDLE: begin
        if (acc) begin
          addr_d     = req_i.data.free_address;
          pages_d    = size_sum[32:bpa_pkg::PAGE_SHIFT];
          want_d     = '0;
          res_addr_d = '0;
          res_stat_d = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::S_A_SIZE: begin
        // Round the page count up to an order, one compare a cycle
        if (size_big) res_stat_d = bpa_pkg::ST_NOBLOCK;
        else if (size_fits) ord_d = want_q;
        else want_d = want_q + OW'(1);
      end
      bpa_pkg::S_A_SRCH: begin
        // Walk up the orders to the first non-empty list
        if (srch_fail) begin
          res_stat_d = bpa_pkg::ST_NOBLOCK;
        end else if (head_sel == bpa_pkg::LINK_NULL) begin
          ord_d = ord_q + OW'(1);
        end else begin
          v_d   = head_sel[PW-1:0];
          x_d   = head_sel[PW-1:0];
          lst_d = ord_q;
          ret_d = bpa_pkg::S_A_SPLIT;
        end
      end
      bpa_pkg::S_A_SPLIT: begin
        // Hand the upper half back to the next list down, or finish
        if (ord_q > want_q) begin
          x_d   = split_buddy;
          lst_d = ord_q - OW'(1);
          ord_d = ord_q - OW'(1);
          ret_d = bpa_pkg::S_A_SPLIT;
        end else begin
          kind_we    = 1'b1;
          kind_wa    = v_q;
          kind_wd    = bpa_pkg::KIND_USED;
          order_we   = 1'b1;
          order_wa   = v_q;
          order_wd   = want_q;
          res_addr_d = base_q + (32'(v_q) << bpa_pkg::PAGE_SHIFT);
        end
      end
      bpa_pkg::S_RM_RD: begin
        rd_addr = x_q;
      end
      bpa_pkg::S_RM_W1: begin
        // Bridge the neighbours of the unlinked block
        if (prev_rd != bpa_pkg::LINK_NULL) begin
          next_we = 1'b1;
          next_wa = prev_rd[PW-1:0];
          next_wd = next_rd;
        end else begin
          head_we = 1'b1;
          head_wd = next_rd;
        end
        if (next_rd != bpa_pkg::LINK_NULL) begin
          prev_we = 1'b1;
          prev_wa = next_rd[PW-1:0];
          prev_wd = prev_rd;
        end else begin
          tail_we = 1'b1;
          tail_wd = prev_rd;
        end
      end
      bpa_pkg::S_RM_W2: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      bpa_pkg::S_PUSH1: begin
        // Append to the back of the list and mark a free head
        t_d      = tail_sel;
        kind_we  = 1'b1;
        order_we = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        prev_wd  = tail_sel;
        tail_we  = 1'b1;
        tail_wd  = {1'b0, x_q};
        if (tail_sel == bpa_pkg::LINK_NULL) begin
          head_we = 1'b1;
          head_wd = {1'b0, x_q};
        end
      end
      bpa_pkg::S_PUSH2: begin
        next_we = 1'b1;
        next_wa = t_q[PW-1:0];
        next_wd = {1'b0, x_q};
      end
      bpa_pkg::S_F_CHK: begin
        rd_addr = off[bpa_pkg::PAGE_SHIFT +: PW];
        v_d     = off[bpa_pkg::PAGE_SHIFT +: PW];
        if (!free_ok) res_stat_d = bpa_pkg::ST_IGNORED;
      end
      bpa_pkg::S_F_TEST: begin
        if (kind_rd == bpa_pkg::KIND_USED) begin
          x_d   = v_q;
          lst_d = order_rd;
          ord_d = order_rd;
          ret_d = bpa_pkg::S_MG_TOP;
        end else begin
          res_stat_d = bpa_pkg::ST_IGNORED;
        end
      end
      bpa_pkg::S_MG_TOP: begin
        // Fetch the buddy of the current block
        rd_addr = buddy;
        b_d     = buddy;
      end
      bpa_pkg::S_MG_TEST: begin
        // Unlink the upper block first, then the lower
        if (merge_ok) begin
          v_d   = (v_q < b_q) ? v_q : b_q;
          b_d   = (v_q < b_q) ? b_q : v_q;
          x_d   = (v_q < b_q) ? b_q : v_q;
          lst_d = ord_q;
          ret_d = bpa_pkg::S_MG_RMLO;
        end
      end
      bpa_pkg::S_MG_RMLO: begin
        x_d   = v_q;
        ret_d = bpa_pkg::S_MG_FIX;
      end
      bpa_pkg::S_MG_FIX: begin
        // Retire the upper block and push the merged one a level up
        kind_we  = 1'b1;
        kind_wa  = b_q;
        kind_wd  = bpa_pkg::KIND_INNER;
        order_we = 1'b1;
        order_wa = b_q;
        order_wd = '0;
        x_d      = v_q;
        lst_d    = ord_q + OW'(1);
        ord_d    = ord_q + OW'(1);
        ret_d    = bpa_pkg::S_MG_TOP;
      end
      bpa_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (load_out) begin
      out_vld_d           = 1'b1;
      out_d.block_address = res_addr_q;
      out_d.status        = res_stat_q;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpa_pkg::S_CLEAR;
      ret_q     <= bpa_pkg::S_IDLE;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      base_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    pages_q    <= pages_d;
    want_q     <= want_d;
    ord_q      <= ord_d;
    lst_q      <= lst_d;
    v_q        <= v_d;
    b_q        <= b_d;
    x_q        <= x_d;
    t_q        <= t_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    out_q      <= out_d;
  end

  // Free-list ends: the top order holds page 0 after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
        head_q[i] <= (i == bpa_pkg::POOL_ORDER) ? '0 : bpa_pkg::LINK_NULL;
        tail_q[i] <= (i == bpa_pkg::POOL_ORDER) ? '0 : bpa_pkg::LINK_NULL;
      end
    end else begin
      if (head_we) head_q[lst_q] <= head_wd;
      if (tail_we) tail_q[lst_q] <= tail_wd;
    end
  end

  // Frame memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    kind_rd <= kind_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    order_rd <= order_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[rd_addr];
  end

endmodule

// ----- verif/tb_buddy_page_allocator.sv -----
// Self-checking testbench for buddy_page_allocator: directed and random allocate/free traffic.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and the buddy_page_allocator RTL.
module tb_buddy_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int LNULL = NUM_PAGES;

  // Buddy pool tracker: predicts each result and queues it for comparison
  class buddy_scoreboard;
    logic [31:0]  region;
    kind_e        kind [NUM_PAGES];
    int           ord [NUM_PAGES];
    int           nxt [NUM_PAGES];
    int           prv [NUM_PAGES];
    int           hd [NUM_ORDERS];
    int           tl [NUM_ORDERS];
    rsp_t         pending_rsp [$];
    int           errors;

    function new();
      for (int i = 0; i < NUM_PAGES; i++) begin
        kind[i] = KIND_INNER; ord[i] = 0; nxt[i] = LNULL; prv[i] = LNULL;
      end
      for (int i = 0; i < NUM_ORDERS; i++) begin
        hd[i] = LNULL; tl[i] = LNULL;
      end
      kind[0] = KIND_FREE;
      ord[0] = POOL_ORDER;
      hd[POOL_ORDER] = 0;
      tl[POOL_ORDER] = 0;
      region = '0;
      errors = 0;
    endfunction

    function void list_append(int o, int v);
      int t;
      t = tl[o];
      prv[v] = t;
      nxt[v] = LNULL;
      if (t < LNULL) nxt[t] = v;
      else hd[o] = v;
      tl[o] = v;
    endfunction

    function void unlink(int o, int v);
      int p, n;
      p = prv[v];
      n = nxt[v];
      if (p < LNULL) nxt[p] = n;
      else hd[o] = n;
      if (n < LNULL) prv[n] = p;
      else tl[o] = p;
      prv[v] = LNULL;
      nxt[v] = LNULL;
    endfunction

    // Note an accepted request, return its predicted result
    function rsp_t note_request(req_t rq);
      rsp_t r;
      longint unsigned pages, off, pg;
      int want, v, b, o, lo, hi;
      bit found;
      r.block_address = '0;
      r.status = ST_DONE;
      if (rq.operation == OP_ALLOC) begin
        pages = (longint'(rq.request_size) + PAGE_BYTES - 1) / PAGE_BYTES;
        want = 0;
        while (want < 40 && (64'd1 << want) < pages) want++;
        found = 0;
        for (o = want; o <= POOL_ORDER && !found; o++) begin
          v = hd[o];
          if (v >= LNULL) continue;
          unlink(o, v);
          kind[v] = KIND_USED;
          while (ord[v] > want) begin
            ord[v] = ord[v] - 1;
            b = v ^ (1 << ord[v]);
            kind[b] = KIND_FREE;
            ord[b] = ord[v];
            list_append(ord[v], b);
          end
          r.block_address = region + 32'(v * PAGE_BYTES);
          found = 1;
        end
        if (!found) r.status = ST_NOBLOCK;
      end else begin
        r.status = ST_IGNORED;
        if (rq.free_address != 0 && rq.free_address >= region) begin
          off = rq.free_address - region;
          pg = off / PAGE_BYTES;
          if (off % PAGE_BYTES == 0 && pg < (1 << POOL_ORDER) && kind[pg] == KIND_USED) begin
            v = int'(pg);
            kind[v] = KIND_FREE;
            list_append(ord[v], v);
            // merge with free buddies while they match
            while (ord[v] < POOL_ORDER) begin
              o = ord[v];
              b = v ^ (1 << o);
              if (b >= LNULL || kind[b] != KIND_FREE || ord[b] != o || kind[v] != KIND_FREE)
                break;
              lo = v < b ? v : b;
              hi = v < b ? b : v;
              unlink(o, hi);
              kind[hi] = KIND_INNER;
              ord[hi] = 0;
              unlink(o, lo);
              ord[lo] = o + 1;
              list_append(o + 1, lo);
              v = lo;
            end
            r.status = ST_DONE;
          end
        end
      end
      pending_rsp = {pending_rsp, r};
      return r;
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: block_address %h status %0d", got.block_address, got.status);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.block_address !== want.block_address) begin
        $error("block_address: expected %h, actual %h", want.block_address, got.block_address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  bit          calm = 1'b0;
  int          held_pages [$];
  int          freed_pages [$];

  bpa_req_if req_if ();
  bpa_rsp_if rsp_if ();
  buddy_scoreboard sb = new();

  buddy_page_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
  end

  // Result side: stall in random bursts unless calm, check on every transaction
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i)
    if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);

  // Drive one request and hold it until it is accepted
  task automatic send(logic op, logic [31:0] size, logic [31:0] addr);
    req_t rq;
    rsp_t r;
    int pg;
    rq.operation = op;
    rq.request_size = size;
    rq.free_address = addr;
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.data = rq;
    do @(posedge clk_i); while (!req_if.ready);
    r = sb.note_request(rq);
    // track held blocks by page so frees stay valid across base changes
    if (op == OP_ALLOC && r.status == ST_DONE)
      held_pages = {held_pages, int'((r.block_address - sb.region) / PAGE_BYTES)};
    if (op == OP_FREE && r.status == ST_DONE) begin
      pg = int'((addr - sb.region) / PAGE_BYTES);
      foreach (held_pages[i]) if (held_pages[i] == pg) begin
        held_pages.delete(i);
        break;
      end
      freed_pages = {freed_pages, pg};
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
    end
  endtask

  task automatic alloc_pages(int n);
    send(OP_ALLOC, 32'(n * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1)), $urandom());
  endtask

  function automatic logic [31:0] page_addr(int pg);
    return sb.region + 32'(pg * PAGE_BYTES);
  endfunction

  // Wait until every predicted result has come back, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_region(logic [31:0] base);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = base;
    sb.region = base;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed alloc/free traffic, with some malformed frees and odd sizes
  task automatic random_phase(int n);
    int k, pg;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        if ($urandom_range(0, 9) == 0) alloc_pages($urandom_range(1, NUM_PAGES));
        else alloc_pages($urandom_range(1, 8));
      end else if (k < 45) begin
        send(OP_ALLOC, $urandom(), $urandom());
      end else if (k < 85 && held_pages.size() != 0) begin
        pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
        send(OP_FREE, $urandom(), page_addr(pg));
      end else if (k < 90 && freed_pages.size() != 0) begin
        pg = freed_pages[$urandom_range(0, freed_pages.size() - 1)];
        send(OP_FREE, $urandom(), page_addr(pg));
      end else if (k < 94 && held_pages.size() != 0) begin
        pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
        send(OP_FREE, $urandom(), page_addr(pg) + $urandom_range(1, PAGE_BYTES - 1));
      end else begin
        send(OP_FREE, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: size extremes, whole pool, ignored frees of zero, misaligned, out-of-pool and repeated addresses
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_ALLOC, 32'd1, 32'hFFFF_FFFF);
    send(OP_ALLOC, 32'd4096, 32'd0);
    send(OP_ALLOC, 32'd4097, 32'd0);
    send(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(OP_ALLOC, 32'(NUM_PAGES * PAGE_BYTES + 1), 32'd0);
    send(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    send(OP_FREE, 32'd0, 32'd4097);
    send(OP_FREE, 32'd0, 32'(NUM_PAGES * PAGE_BYTES));
    send(OP_FREE, 32'd0, 32'hFFFF_FFFF);
    send(OP_FREE, 32'd0, 32'(2 * PAGE_BYTES));
    send(OP_FREE, 32'd0, 32'(2 * PAGE_BYTES));
    send(OP_FREE, 32'd0, 32'(4 * PAGE_BYTES));
    send(OP_FREE, 32'd0, 32'(1 * PAGE_BYTES));
    send(OP_FREE, 32'd0, 32'(8 * PAGE_BYTES));
    held_pages.delete();
    drain();
    send(OP_ALLOC, 32'(NUM_PAGES * PAGE_BYTES), 32'd0);
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_FREE, 32'd0, 32'd0);
    drain();

    // Top of the address space: results wrap, low frees fall below the base
    set_region(32'hFFFF_F000);
    send(OP_ALLOC, 32'd1, 32'd0);
    send(OP_FREE, 32'd0, 32'd0);
    send(OP_FREE, 32'd0, 32'h0000_1000);
    random_phase(200);
    drain();

    set_region({20'($urandom_range(0, 32'hFFFFF)), 12'h000});
    random_phase(100);
    // hold off until every result is back, then carry on
    drain();
    random_phase(100);
    drain();

    set_region(32'h0040_0000);
    random_phase(200);
    drain();

    set_region(32'h0000_0000);
    calm = 1'b1;
    random_phase(200);
    drain();

    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("** buddy_page_allocator: PASSED **");
    end else begin
      $display("** buddy_page_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("** buddy_page_allocator: FAILED **");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/buddy_page_allocator.sv
verif/tb_buddy_page_allocator.sv
